>>> hdl/pbrle_pkg.sv
// Shared constants and types of the PackBits run-length encoder.
package pbrle_pkg;

    localparam int BYTE_W               = 8;
    localparam int CODE_W               = 32;
    localparam int COUNT_W              = 3;
    localparam int MAX_RUN_DEF          = 128;
    localparam int BYTES_PER_RESULT_DEF = 4;

    // One code byte handed from the sequencer to the packer.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [BYTE_W-1:0] data;
    } beat_t;

endpackage

>>> hdl/pbrle_if.sv
// Raw-byte and code-word channel interfaces of the PackBits encoder.
interface pbrle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface pbrle_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] code_bytes;
    logic [2:0]  byte_count;
    logic        last_of_run;

    modport source (output valid, output code_bytes, output byte_count, output last_of_run,
                    input ready);
    modport sink (input valid, input code_bytes, input byte_count, input last_of_run,
                  output ready);
endinterface

>>> hdl/pbrle_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pbrle_ram #(
    parameter int WIDTH = pbrle_pkg::BYTE_W,
    parameter int DEPTH = pbrle_pkg::MAX_RUN_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/pbrle_ctrl.sv
// Run tracking and code-byte sequencer around the literal store.
module pbrle_ctrl #(
    parameter int MAX_RUN = pbrle_pkg::MAX_RUN_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    pbrle_in_if.sink                   raw,
    output pbrle_pkg::beat_t           beat,
    input  logic                       take,
    output logic                       we,
    output logic [$clog2(MAX_RUN)-1:0] waddr,
    output logic [pbrle_pkg::BYTE_W-1:0] wdata,
    output logic [$clog2(MAX_RUN)-1:0] raddr,
    input  logic [pbrle_pkg::BYTE_W-1:0] rdata
);

    localparam int AW = $clog2(MAX_RUN);
    localparam int CW = $clog2(MAX_RUN + 1);
    localparam logic [CW-1:0] LIMIT = CW'(MAX_RUN);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_HDR  = 3'b010,
        S_BODY = 3'b100
    } state_t;

    state_t                        state_reg, state_next;
    logic [pbrle_pkg::BYTE_W-1:0]  prior_reg;
    logic [CW-1:0]                 run_reg;
    logic                          known_reg;
    logic                          rep_reg;
    logic                          cur_rep_reg;
    logic [CW-1:0]                 cur_len_reg;
    logic [pbrle_pkg::BYTE_W-1:0]  cur_byte_reg;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic                          fl_pend_reg;
    logic                          fl_rep_reg;
    logic [CW-1:0]                 fl_len_reg;
    logic [pbrle_pkg::BYTE_W-1:0]  fl_byte_reg;
    logic                          wr_pend_reg;
    logic [AW-1:0]                 wr_addr_reg;
    logic [pbrle_pkg::BYTE_W-1:0]  wr_data_reg;

    logic                          accept;
    logic                          same;
    logic [CW-1:0]                 d_run;
    logic                          d_known;
    logic                          d_rep;
    logic                          d_wr;
    logic [AW-1:0]                 d_waddr;
    logic                          mid_v;
    logic                          mid_rep;
    logic [CW-1:0]                 mid_len;
    logic                          fl_rep;
    logic [CW-1:0]                 idx_inc;
    logic                          seq_end;
    logic [pbrle_pkg::BYTE_W-1:0]  hdr_byte;
    logic                          seq_done;

    assign raw.ready = (state_reg == S_IDLE);
    assign accept    = raw.valid && raw.ready;
    assign same      = (raw.data_byte == prior_reg);

    // Next run state and the sequence closed by this byte, if any.
    always_comb
    begin
        d_run   = run_reg;
        d_known = known_reg;
        d_rep   = rep_reg;
        d_wr    = 1'b0;
        d_waddr = '0;
        mid_v   = 1'b0;
        mid_rep = 1'b0;
        mid_len = run_reg;
        if (run_reg == '0)
        begin
            d_wr    = 1'b1;
            d_run   = CW'(1);
            d_known = 1'b0;
        end
        else if (!known_reg)
        begin
            d_rep   = same;
            d_known = 1'b1;
            d_wr    = 1'b1;
            d_waddr = AW'(run_reg);
            d_run   = run_reg + CW'(1);
        end
        else if (same && rep_reg && run_reg < LIMIT)
        begin
            d_run = run_reg + CW'(1);
        end
        else if (!same && !rep_reg && run_reg < LIMIT)
        begin
            d_wr    = 1'b1;
            d_waddr = AW'(run_reg);
            d_run   = run_reg + CW'(1);
        end
        else if (rep_reg)
        begin
            mid_v   = 1'b1;
            mid_rep = 1'b1;
            d_wr    = 1'b1;
            d_run   = CW'(1);
            d_known = 1'b0;
        end
        else if (run_reg >= LIMIT)
        begin
            mid_v   = 1'b1;
            d_wr    = 1'b1;
            d_run   = CW'(1);
            d_known = 1'b0;
        end
        else
        begin
            // two equal neighbors: close the literal, open a repeat run
            mid_v   = 1'b1;
            mid_len = run_reg - CW'(1);
            d_known = 1'b1;
            d_rep   = 1'b1;
            d_run   = CW'(2);
        end
        fl_rep = d_known && d_rep;
    end

    assign hdr_byte = cur_rep_reg ? 8'(9'd257 - 9'(cur_len_reg))
                                  : 8'(9'(cur_len_reg) - 9'd1);
    assign idx_inc  = idx_reg + CW'(1);
    assign seq_end  = cur_rep_reg || (idx_inc == cur_len_reg);
    assign seq_done = (state_reg == S_BODY) && take && seq_end;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = '0;
        beat       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (mid_v || raw.end_of_buffer))
                begin
                    state_next = S_HDR;
                end
            end
            S_HDR:
            begin
                beat.valid = 1'b1;
                beat.data  = hdr_byte;
                if (take)
                begin
                    state_next = S_BODY;
                end
            end
            S_BODY:
            begin
                beat.valid = 1'b1;
                beat.data  = cur_rep_reg ? cur_byte_reg : rdata;
                beat.last  = seq_end && !fl_pend_reg;
                idx_next   = idx_reg;
                if (take)
                begin
                    if (seq_end)
                    begin
                        idx_next   = '0;
                        state_next = fl_pend_reg ? S_HDR : S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the read address while the packer stalls so the read data stays put.
    assign raddr = AW'(idx_next);

    // A write behind a closed literal waits until that literal has been read out.
    always_comb
    begin
        if (seq_done && wr_pend_reg)
        begin
            we    = 1'b1;
            waddr = wr_addr_reg;
            wdata = wr_data_reg;
        end
        else
        begin
            we    = accept && d_wr && !mid_v;
            waddr = d_waddr;
            wdata = raw.data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            prior_reg   <= '0;
            run_reg     <= '0;
            known_reg   <= 1'b0;
            rep_reg     <= 1'b0;
            idx_reg     <= '0;
            fl_pend_reg <= 1'b0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (accept)
            begin
                prior_reg   <= raw.data_byte;
                fl_pend_reg <= mid_v && raw.end_of_buffer;
                wr_pend_reg <= mid_v && d_wr;
                if (raw.end_of_buffer)
                begin
                    run_reg   <= '0;
                    known_reg <= 1'b0;
                    rep_reg   <= 1'b0;
                end
                else
                begin
                    run_reg   <= d_run;
                    known_reg <= d_known;
                    rep_reg   <= d_rep;
                end
            end
            else if (seq_done)
            begin
                fl_pend_reg <= 1'b0;
                wr_pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_rep_reg  <= mid_v ? mid_rep : fl_rep;
            cur_len_reg  <= mid_v ? mid_len : d_run;
            cur_byte_reg <= mid_v ? prior_reg : raw.data_byte;
            fl_rep_reg   <= fl_rep;
            fl_len_reg   <= d_run;
            fl_byte_reg  <= raw.data_byte;
            wr_addr_reg  <= d_waddr;
            wr_data_reg  <= raw.data_byte;
        end
        else if (seq_done && fl_pend_reg)
        begin
            // advance to the end-of-buffer flush
            cur_rep_reg  <= fl_rep_reg;
            cur_len_reg  <= fl_len_reg;
            cur_byte_reg <= fl_byte_reg;
        end
    end

`ifndef SYNTHESIS
    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg <= LIMIT)
        else $error("pending run longer than the cap");

    a_known_len: assert property (@(posedge clk) disable iff (!rst_n)
        known_reg |-> run_reg >= CW'(2))
        else $error("decided sequence holds fewer than two bytes");

    a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && raw.end_of_buffer) |=> (run_reg == '0 && !known_reg))
        else $error("run state not cleared after last byte of buffer");

    a_wr_pend: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> state_reg != S_IDLE)
        else $error("deferred store write left behind in idle");
`endif

endmodule

>>> hdl/pbrle_packer.sv
// Packs the code-byte stream into result words behind an output register.
module pbrle_packer #(
    parameter int BYTES_PER_RESULT = pbrle_pkg::BYTES_PER_RESULT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pbrle_pkg::beat_t beat,
    output logic             take,
    pbrle_out_if.source      code
);

    localparam int PackW = BYTES_PER_RESULT * pbrle_pkg::BYTE_W;
    localparam int AccW  = (PackW > pbrle_pkg::CODE_W) ? PackW : pbrle_pkg::CODE_W;
    localparam int CntW  = $clog2(BYTES_PER_RESULT + 1);

    logic [AccW-1:0]                   acc_reg, acc_next;
    logic [CntW-1:0]                   cnt_reg;
    logic [CntW-1:0]                   cnt_inc;
    logic                              out_valid_reg;
    logic [pbrle_pkg::CODE_W-1:0]      code_reg;
    logic [pbrle_pkg::COUNT_W-1:0]     count_reg;
    logic                              last_reg;
    logic                              complete;
    logic                              free;
    logic                              load;

    assign cnt_inc  = cnt_reg + CntW'(1);
    assign complete = beat.valid && (cnt_inc == CntW'(BYTES_PER_RESULT) || beat.last);
    assign free     = !out_valid_reg || code.ready;
    assign take     = beat.valid && (!complete || free);
    assign load     = take && complete;
    assign acc_next = ((cnt_reg == '0) ? '0 : acc_reg)
                    | (AccW'(beat.data) << {cnt_reg, 3'b000});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                cnt_reg <= complete ? '0 : cnt_inc;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (code.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !complete)
        begin
            acc_reg <= acc_next;
        end
        if (load)
        begin
            code_reg  <= acc_next[pbrle_pkg::CODE_W-1:0];
            count_reg <= pbrle_pkg::COUNT_W'(cnt_inc);
            last_reg  <= beat.last;
        end
    end

    assign code.valid       = out_valid_reg;
    assign code.code_bytes  = code_reg;
    assign code.byte_count  = count_reg;
    assign code.last_of_run = last_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CntW'(BYTES_PER_RESULT))
        else $error("packer byte count past word size");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> code.valid)
        else $error("finished word not presented");
`endif

endmodule

>>> hdl/packbits_run_length_encoder.sv
// PackBits encoder top level: one raw byte in, packed code words out.
// An input byte that closes no sequence leaves the block ready for more input.
// A byte releasing code bytes stalls input until all are out; the sequencer moves
// one code byte per cycle unless the packer stalls, literals via the store's one
// read port. A result word shows in the cycle after its final code byte is packed.
// Reset clears the run state and handshakes; the literal store is not cleared.
module packbits_run_length_encoder #(
    parameter int MAX_RUN          = pbrle_pkg::MAX_RUN_DEF,
    parameter int BYTES_PER_RESULT = pbrle_pkg::BYTES_PER_RESULT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pbrle_in_if.sink    raw,
    pbrle_out_if.source code
);

    localparam int AW = $clog2(MAX_RUN);

    pbrle_pkg::beat_t               beat;
    logic                           take;
    logic                           we;
    logic [AW-1:0]                  waddr;
    logic [pbrle_pkg::BYTE_W-1:0]   wdata;
    logic [AW-1:0]                  raddr;
    logic [pbrle_pkg::BYTE_W-1:0]   rdata;

    pbrle_ctrl #(
        .MAX_RUN (MAX_RUN)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw),
        .beat  (beat),
        .take  (take),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    pbrle_ram #(
        .WIDTH (pbrle_pkg::BYTE_W),
        .DEPTH (MAX_RUN)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    pbrle_packer #(
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_packer (
        .clk   (clk),
        .rst_n (rst_n),
        .beat  (beat),
        .take  (take),
        .code  (code)
    );

endmodule
